>>> design/ibs_pkg.sv
// Shared constants, codes and types of the indexed block search unit.
package ibs_pkg;

   localparam int NUM_BLOCKS  = 4;
   localparam int BLOCK_SIZE  = 8;
   localparam int WORD_BITS   = 32;
   localparam int STORE_DEPTH = 32;

   localparam int ADDR_BITS   = $clog2(STORE_DEPTH);
   localparam int CSR_BITS    = 3;
   localparam int IDX_BITS    = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
   localparam int BLK_CNT_BITS = $clog2(NUM_BLOCKS + 1);
   localparam int LIM_BITS    = (BLK_CNT_BITS > CSR_BITS) ? BLK_CNT_BITS : CSR_BITS;
   localparam int OFF_BITS    = $clog2(BLOCK_SIZE + 1);

   localparam logic [CSR_BITS-1:0] BLOCKS_IN_USE_RESET = CSR_BITS'(4);

   localparam logic [1:0] OP_WRITE_DATA  = 2'd0;
   localparam logic [1:0] OP_WRITE_INDEX = 2'd1;
   localparam logic [1:0] OP_LOOKUP      = 2'd2;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_WALK,
      ST_SCAN,
      ST_DONE
   } state_type;

endpackage

>>> design/ibs_ram.sv
// Generic single write port, single read port RAM with registered read data.
module ibs_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> design/indexed_block_search_unit.sv
// Top level of the indexed block search unit: index walk and block scan sequencer.
// A lookup is accepted, walks the index, scans the qualifying block if one is found (one word
// store read per cycle, each word compared in the cycle after its read), and then loads the
// output register, which can be held by rsp_ready stalls.
// One transaction at a time.
// Synchronous active-high reset clears control state and sets blocks_in_use to 4.
module indexed_block_search_unit (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [1:0]                    req_opcode,
   input  logic [4:0]                    req_slot,
   input  logic signed [31:0]            req_value,
   input  logic [4:0]                    req_block_start,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic                          rsp_found,
   output logic [4:0]                    rsp_position,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [ibs_pkg::CSR_BITS-1:0]  csr_data
);

   localparam int WB = ibs_pkg::WORD_BITS;
   localparam int AB = ibs_pkg::ADDR_BITS;
   localparam int LB = ibs_pkg::LIM_BITS;
   localparam int OB = ibs_pkg::OFF_BITS;
   localparam int IB = ibs_pkg::IDX_BITS;

   ibs_pkg::state_type state_ff, state_in;

   logic [ibs_pkg::CSR_BITS-1:0] blocks_in_use_ff;
   logic signed [WB-1:0] index_keys_ff [ibs_pkg::NUM_BLOCKS];
   logic [AB-1:0] index_starts_ff [ibs_pkg::NUM_BLOCKS];

   logic [LB-1:0] limit_ff, limit_in;
   logic [LB-1:0] blk_ff, blk_in;
   logic [OB-1:0] off_ff, off_in;
   logic signed [WB-1:0] key_ff, key_in;
   logic [AB-1:0] start_ff, start_in;
   logic cmp_valid_ff, cmp_valid_in;
   logic [AB-1:0] cmp_addr_ff, cmp_addr_in;
   logic res_found_ff, res_found_in;
   logic [AB-1:0] res_pos_ff, res_pos_in;

   logic rsp_valid_ff, rsp_valid_in;
   logic rsp_found_ff, rsp_found_in;
   logic [AB-1:0] rsp_position_ff, rsp_position_in;

   logic req_fire;
   logic out_free;
   logic [LB-1:0] csr_limit;
   logic [IB-1:0] walk_idx;
   logic ram_wr_en;
   logic ram_rd_en;
   logic [AB-1:0] ram_rd_addr;
   logic [WB-1:0] ram_rd_data;

   assign req_ready = (state_ff == ibs_pkg::ST_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign csr_ready = 1'b1;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign walk_idx  = blk_ff[IB-1:0];
   assign ram_wr_en = req_fire && (req_opcode == ibs_pkg::OP_WRITE_DATA);
   assign ram_rd_addr = start_ff + AB'(off_ff);

   // saturate the block count at the index depth
   assign csr_limit = (LB'(blocks_in_use_ff) > LB'(ibs_pkg::NUM_BLOCKS)) ?
                      LB'(ibs_pkg::NUM_BLOCKS) : LB'(blocks_in_use_ff);

   ibs_ram #(
      .WIDTH(WB),
      .DEPTH(ibs_pkg::STORE_DEPTH)
   ) u_word_store (
      .clock  (clock),
      .wr_en  (ram_wr_en),
      .wr_addr(req_slot),
      .wr_data(req_value),
      .rd_en  (ram_rd_en),
      .rd_addr(ram_rd_addr),
      .rd_data(ram_rd_data)
   );

   always_comb begin
      state_in        = state_ff;
      limit_in        = limit_ff;
      blk_in          = blk_ff;
      off_in          = off_ff;
      key_in          = key_ff;
      start_in        = start_ff;
      cmp_valid_in    = 1'b0;
      cmp_addr_in     = cmp_addr_ff;
      res_found_in    = res_found_ff;
      res_pos_in      = res_pos_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_ready;
      rsp_found_in    = rsp_found_ff;
      rsp_position_in = rsp_position_ff;
      ram_rd_en       = 1'b0;

      unique case (state_ff)
         ibs_pkg::ST_IDLE: begin
            if (req_fire && (req_opcode == ibs_pkg::OP_LOOKUP)) begin
               key_in   = req_value;
               limit_in = csr_limit;
               blk_in   = '0;
               state_in = ibs_pkg::ST_WALK;
            end
         end
         ibs_pkg::ST_WALK: begin
            if (blk_ff == limit_ff) begin
               // no entry qualifies: fail
               res_found_in = 1'b0;
               res_pos_in   = '0;
               state_in     = ibs_pkg::ST_DONE;
            end else if (key_ff <= index_keys_ff[walk_idx]) begin
               start_in = index_starts_ff[walk_idx];
               off_in   = '0;
               state_in = ibs_pkg::ST_SCAN;
            end else begin
               blk_in = blk_ff + LB'(1);
            end
         end
         ibs_pkg::ST_SCAN: begin
            if (cmp_valid_ff && (ram_rd_data == key_ff)) begin
               res_found_in = 1'b1;
               res_pos_in   = cmp_addr_ff;
               state_in     = ibs_pkg::ST_DONE;
            end else if (off_ff < OB'(ibs_pkg::BLOCK_SIZE)) begin
               // issue the next read; compare its word next cycle
               ram_rd_en    = 1'b1;
               off_in       = off_ff + OB'(1);
               cmp_valid_in = 1'b1;
               cmp_addr_in  = ram_rd_addr;
            end else begin
               res_found_in = 1'b0;
               res_pos_in   = '0;
               state_in     = ibs_pkg::ST_DONE;
            end
         end
         ibs_pkg::ST_DONE: begin
            // hold until the output register frees up
            if (out_free) begin
               rsp_valid_in    = 1'b1;
               rsp_found_in    = res_found_ff;
               rsp_position_in = res_pos_ff;
               state_in        = ibs_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = ibs_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ibs_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
         cmp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         cmp_valid_ff <= cmp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         blocks_in_use_ff <= ibs_pkg::BLOCKS_IN_USE_RESET;
      end else if (csr_valid && csr_ready) begin
         blocks_in_use_ff <= csr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire && (req_opcode == ibs_pkg::OP_WRITE_INDEX) &&
          (req_slot < 5'(ibs_pkg::NUM_BLOCKS))) begin
         index_keys_ff[req_slot[IB-1:0]]   <= req_value;
         index_starts_ff[req_slot[IB-1:0]] <= req_block_start;
      end
   end

   always_ff @(posedge clock) begin
      limit_ff        <= limit_in;
      blk_ff          <= blk_in;
      off_ff          <= off_in;
      key_ff          <= key_in;
      start_ff        <= start_in;
      cmp_addr_ff     <= cmp_addr_in;
      res_found_ff    <= res_found_in;
      res_pos_ff      <= res_pos_in;
      rsp_found_ff    <= rsp_found_in;
      rsp_position_ff <= rsp_position_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_found    = rsp_found_ff;
   assign rsp_position = rsp_position_ff;

   // a block is scanned only after an index entry within the limit qualified
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ibs_pkg::ST_SCAN) |-> (blk_ff < limit_ff))
      else $error("scan started without a qualifying index entry");

   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ibs_pkg::ST_SCAN) |-> (off_ff <= OB'(ibs_pkg::BLOCK_SIZE)))
      else $error("scan ran past the block");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_found_ff) |-> (rsp_position_ff == '0))
      else $error("failed lookup with nonzero position");

   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ibs_pkg::ST_DONE && out_free) |=>
         (rsp_valid_ff && state_ff == ibs_pkg::ST_IDLE))
      else $error("finished lookup not delivered to the output register");

   assert property (@(posedge clock) disable iff (reset)
      (state_ff != ibs_pkg::ST_IDLE) |-> !ram_wr_en)
      else $error("word store written during a lookup");

endmodule
